@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the soft pitch quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int PIPE_LATENCY = 82;
  localparam int SQ_STEPS     = 30;
  localparam int VN_STEPS     = 15;
  localparam int TAYLOR_TERMS = 14;

  localparam logic [16:0] ONE     = 17'h10000;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] Q30_ONE = 31'h40000000;

  localparam logic signed [25:0] PITCH_MAX = 26'sd8388607;
  localparam logic signed [25:0] PITCH_MIN = -26'sd8388608;

  localparam logic REG_POS_ORDER = 1'b0;
  localparam logic REG_VEL_ORDER = 1'b1;

  typedef struct packed {
    logic [3:0] porder;
    logic [3:0] vorder;
  } cfg_t;

  typedef struct packed {
    logic [5:0]         voice;
    logic signed [23:0] x;
    logic signed [24:0] ro;
    logic               relneg;
    logic               azero;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] m;
    logic [29:0] f;
    logic [4:0]  lp;
    logic [16:0] v;
    logic [16:0] vn;
  } log_t;

endpackage

`default_nettype wire

@@ rtl/spq_front.sv @@
// ----------------------------------------------------------------------------
// spq_front
// Round to the nearest semitone, velocity weight, and log2 normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_front (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire         [5:0]  voice_id,
  input  wire  signed [23:0] pitch_in,
  input  wire  signed [23:0] pitch_speed,
  output logic               vld,
  output spq_pkg::log_t      st2
);

  logic                s1_vld;
  spq_pkg::side_t      s1_side;
  logic [16:0]         s1_a;
  logic [16:0]         s1_v;

  logic signed [24:0]  xs;
  logic signed [24:0]  rnd;
  logic signed [24:0]  ro_c;
  logic signed [24:0]  rel;
  logic signed [24:0]  arel;
  logic signed [24:0]  s_ext;
  logic signed [24:0]  sa25;
  logic [16:0]         a_c;
  logic [16:0]         v_c;
  logic [4:0]          lp_c;
  logic [30:0]         m_c;

  always_comb begin
    xs    = 25'(pitch_in);
    rnd   = xs + 25'sd32768;
    ro_c  = {rnd[24:16], 16'b0};
    rel   = xs - ro_c;
    arel  = rel[24] ? -rel : rel;
    a_c   = {arel[15:0], 1'b0};
    s_ext = 25'(pitch_speed);
    sa25  = s_ext[24] ? -s_ext : s_ext;
    if (sa25[23:0] >= 24'h010000) begin
      v_c = 17'd0;
    end else begin
      v_c = spq_pkg::ONE - sa25[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
    s1_side.voice  <= voice_id;
    s1_side.x      <= pitch_in;
    s1_side.ro     <= ro_c;
    s1_side.relneg <= rel[24];
    s1_side.azero  <= (a_c == 17'd0);
    s1_a           <= a_c;
    s1_v           <= v_c;
  end

  always_comb begin
    lp_c = 5'd0;
    for (int b = 0; b < 17; b++) begin
      if (s1_a[b]) begin
        lp_c = 5'(b);
      end
    end
    m_c = 31'(s1_a) << (5'd30 - lp_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= s1_vld;
    end
    st2.side <= s1_side;
    st2.m    <= m_c;
    st2.f    <= 30'd0;
    st2.lp   <= lp_c;
    st2.v    <= s1_v;
    st2.vn   <= spq_pkg::ONE;
  end

  a_norm: assert property (@(posedge clk) disable iff (rst)
    (s1_vld && s1_a != 17'd0) |=> st2.m[30])
    else $error("mantissa not normalized");

endmodule

`default_nettype wire

@@ rtl/spq_log.sv @@
// ----------------------------------------------------------------------------
// spq_log
// Squaring pipeline for the log2 fraction, with the velocity power lane.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_log (
  input  wire                clk,
  input  wire                rst,
  input  spq_pkg::cfg_t      cfg,
  input  wire                in_vld,
  input  spq_pkg::log_t      in_st,
  output logic               out_vld,
  output spq_pkg::log_t      out_st
);

  localparam int N = spq_pkg::SQ_STEPS;

  spq_pkg::log_t st  [0:N-1];
  logic          vld [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_sq
    spq_pkg::log_t cur;
    logic          cur_vld;
    spq_pkg::log_t nxt;
    logic [61:0]   sq;
    logic [31:0]   mm;
    logic [33:0]   vnp;

    if (i == 0) begin : g_first
      assign cur     = in_st;
      assign cur_vld = in_vld;
    end else begin : g_rest
      assign cur     = st[i-1];
      assign cur_vld = vld[i-1];
    end

    always_comb begin
      nxt  = cur;
      sq   = 62'(cur.m) * 62'(cur.m);
      mm   = sq[61:30];
      vnp  = 34'(cur.vn) * 34'(cur.v);
      if (mm[31]) begin
        nxt.m = mm[31:1];
      end else begin
        nxt.m = mm[30:0];
      end
      nxt.f[29-i] = mm[31];
      if (i < spq_pkg::VN_STEPS) begin
        if (4'(i) < cfg.vorder) begin
          nxt.vn = vnp[32:16];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= cur_vld;
      end
      st[i] <= nxt;
    end
  end

  assign out_vld = vld[N-1];
  assign out_st  = st[N-1];

endmodule

`default_nettype wire

@@ rtl/spq_exp.sv @@
// ----------------------------------------------------------------------------
// spq_exp
// Exponent product, 2^y Taylor pipeline and final power scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_exp (
  input  wire                clk,
  input  wire                rst,
  input  spq_pkg::cfg_t      cfg,
  input  wire                in_vld,
  input  spq_pkg::log_t      in_st,
  output logic               out_vld,
  output spq_pkg::side_t     out_side,
  output logic [31:0]        ak
);

  typedef struct packed {
    spq_pkg::side_t side;
    logic           tzero;
    logic [8:0]     q;
    logic [29:0]    xln;
    logic [30:0]    term;
    logic [32:0]    sum;
  } tay_t;

  localparam int NT = spq_pkg::TAYLOR_TERMS;

  logic           e0_vld, e1_vld, e2_vld, e3_vld, e4_vld, e5_vld;
  spq_pkg::side_t e0_side, e1_side, e2_side, e3_side, e4_side;
  logic [34:0]    e0_nl;
  logic [19:0]    e0_k, e1_k;
  logic [16:0]    e1_nlhi;
  logic [37:0]    e1_plo, e2_plo;
  logic [36:0]    e2_phi;
  logic [38:0]    e3_t;
  logic           e4_tzero;
  logic [8:0]     e4_q;
  logic [30:0]    e4_y;
  tay_t           e5;

  logic [4:0]     lpd;
  logic [54:0]    full;
  logic [60:0]    xprod;

  assign lpd  = 5'd16 - in_st.lp;
  assign full = {e2_phi, 18'b0} + 55'(e2_plo);
  assign xprod = 61'(e4_y) * 61'(spq_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_vld <= 1'b0;
      e1_vld <= 1'b0;
      e2_vld <= 1'b0;
      e3_vld <= 1'b0;
      e4_vld <= 1'b0;
      e5_vld <= 1'b0;
    end else begin
      e0_vld <= in_vld;
      e1_vld <= e0_vld;
      e2_vld <= e1_vld;
      e3_vld <= e2_vld;
      e4_vld <= e3_vld;
      e5_vld <= e4_vld;
    end
    e0_side  <= in_st.side;
    e0_nl    <= {lpd, 30'b0} - 35'(in_st.f);
    e0_k     <= 20'(spq_pkg::ONE) + 20'(4'(cfg.porder - 4'd1)) * 20'(in_st.vn);
    e1_side  <= e0_side;
    e1_k     <= e0_k;
    e1_nlhi  <= e0_nl[34:18];
    e1_plo   <= 38'(e0_k) * 38'(e0_nl[17:0]);
    e2_side  <= e1_side;
    e2_plo   <= e1_plo;
    e2_phi   <= 37'(e1_k) * 37'(e1_nlhi);
    e3_side  <= e2_side;
    e3_t     <= full[54:16];
    e4_side  <= e3_side;
    e4_tzero <= (e3_t == 39'd0);
    e4_q     <= e3_t[38:30];
    e4_y     <= spq_pkg::Q30_ONE - {1'b0, e3_t[29:0]};
    e5.side  <= e4_side;
    e5.tzero <= e4_tzero;
    e5.q     <= e4_q;
    e5.xln   <= xprod[59:30];
    e5.term  <= spq_pkg::Q30_ONE;
    e5.sum   <= 33'(spq_pkg::Q30_ONE);
  end

  tay_t tc     [0:NT-1];
  logic tc_vld [0:NT-1];

  for (genvar j = 0; j < NT; j++) begin : g_tay
    localparam logic [30:0] RECIP = 31'((64'd1 << 30) / (j + 1));
    localparam logic [33:0] NDIV  = 34'(j + 1);
    tay_t        cur;
    logic        cur_vld;
    tay_t        ta, tb;
    logic        ta_vld, tb_vld;
    logic [29:0] vva, vvb, q0b;
    logic [60:0] p1, p2;
    logic [33:0] rem;
    logic [29:0] tn;
    tay_t        nt;

    if (j == 0) begin : g_first
      assign cur     = e5;
      assign cur_vld = e5_vld;
    end else begin : g_rest
      assign cur     = tc[j-1];
      assign cur_vld = tc_vld[j-1];
    end

    always_comb begin
      p1  = 61'(cur.term) * 61'(cur.xln);
      p2  = 61'(vva) * 61'(RECIP);
      rem = 34'(vvb) - 34'(q0b) * NDIV;
      tn  = (rem >= NDIV) ? q0b + 30'd1 : q0b;
      nt      = tb;
      nt.term = 31'(tn);
      nt.sum  = tb.sum + 33'(tn);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ta_vld    <= 1'b0;
        tb_vld    <= 1'b0;
        tc_vld[j] <= 1'b0;
      end else begin
        ta_vld    <= cur_vld;
        tb_vld    <= ta_vld;
        tc_vld[j] <= tb_vld;
      end
      ta  <= cur;
      vva <= p1[59:30];
      tb  <= ta;
      vvb <= vva;
      q0b <= p2[59:30];
      tc[j] <= nt;
    end
  end

  tay_t        last;
  logic [31:0] e;
  logic [31:0] ak_c;

  assign last = tc[NT-1];
  assign e    = last.sum[32:1];

  always_comb begin
    if (last.side.azero) begin
      ak_c = 32'd0;
    end else if (last.tzero) begin
      ak_c = 32'(spq_pkg::Q30_ONE);
    end else if (last.q >= 9'd62) begin
      ak_c = 32'd0;
    end else begin
      ak_c = e >> last.q[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= tc_vld[NT-1];
    end
    out_side <= last.side;
    ak       <= ak_c;
  end

endmodule

`default_nettype wire

@@ rtl/soft_pitch_quantizer_unit.sv @@
// ----------------------------------------------------------------------------
// soft_pitch_quantizer_unit
// Per-voice pitch quantizer: round, pass through or soft snap to semitones.
// Throughput: one word per cycle through the 82-stage pipe; busy never rises.
// Results leave on done for one cycle; the receiver cannot stall.
// Reset clears all stage valid bits and both order registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_pitch_quantizer_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire         [5:0]  voice_id,
  input  wire  signed [23:0] pitch_in,
  input  wire  signed [23:0] pitch_speed,
  output logic               done,
  output logic        [5:0]  voice_out,
  output logic signed [23:0] pitch_out,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire         [2:0]  paddr,
  input  wire         [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  spq_pkg::cfg_t  cfg;
  logic           f_vld, l_vld, x_vld;
  spq_pkg::log_t  f_st, l_st;
  spq_pkg::side_t x_side;
  logic [31:0]    ak;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == spq_pkg::REG_POS_ORDER) begin
        cfg.porder <= pwdata[3:0];
      end else begin
        cfg.vorder <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == spq_pkg::REG_VEL_ORDER) ? {28'b0, cfg.vorder}
                                                       : {28'b0, cfg.porder};

  spq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !busy),
    .voice_id    (voice_id),
    .pitch_in    (pitch_in),
    .pitch_speed (pitch_speed),
    .vld         (f_vld),
    .st2         (f_st)
  );

  spq_log u_log (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_vld  (f_vld),
    .in_st   (f_st),
    .out_vld (l_vld),
    .out_st  (l_st)
  );

  spq_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_vld   (l_vld),
    .in_st    (l_st),
    .out_vld  (x_vld),
    .out_side (x_side),
    .ak       (ak)
  );

  logic [32:0]        offs;
  logic signed [25:0] ro26, off26, snap, res;

  always_comb begin
    offs  = 33'(ak) + 33'h4000;
    ro26  = 26'(x_side.ro);
    off26 = signed'(26'(offs[32:15]));
    snap  = x_side.relneg ? ro26 - off26 : ro26 + off26;
    case (cfg.porder)
      4'd0:    res = ro26;
      4'd1:    res = 26'(x_side.x);
      default: res = snap;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= x_vld;
    end
    voice_out <= x_side.voice;
    if (res > spq_pkg::PITCH_MAX) begin
      pitch_out <= 24'sh7FFFFF;
    end else if (res < spq_pkg::PITCH_MIN) begin
      pitch_out <= -24'sh800000;
    end else begin
      pitch_out <= res[23:0];
    end
  end

  done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, spq_pkg::PIPE_LATENCY))
    else $error("result without accepted word");

  voice_keep: assert property (@(posedge clk) disable iff (rst)
    done |-> voice_out == $past(voice_id, spq_pkg::PIPE_LATENCY))
    else $error("voice id lost in pipeline");

  never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

`default_nettype wire
